// ===== design/rtpfua_pkg.sv =====
package rtpfua_pkg;

  // default width of the nal length counter
  localparam int NAL_LENGTH_BITS_DEFAULT = 24;

  // width of the nal_length field on the input channel
  localparam int NAL_LENGTH_FIELD_BITS = 24;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // config port
  localparam int CFG_ADDR_BITS = 4;
  localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd0;
  localparam logic [1:0] REG_STREAM_SOURCE_ID = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD_BYTES = 2'd2;

  // register reset values
  localparam logic [6:0] PAYLOAD_TYPE_RESET = 7'd96;
  localparam logic [31:0] STREAM_SOURCE_ID_RESET = 32'd10;
  localparam logic [10:0] MAX_PAYLOAD_RESET = 11'd1460;

  // payload size limits
  localparam logic [10:0] MIN_PAYLOAD = 11'd16;
  localparam logic [10:0] MAX_PAYLOAD = 11'd1460;
  localparam logic [10:0] FU_OVERHEAD = 11'd2;

  // rtp and fu-a header constants
  localparam logic [15:0] SEQ_RESET = 16'd1;
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] NRI_F_MASK = 8'hE0;
  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_START_BIT = 8'h80;
  localparam logic [7:0] FU_END_BIT = 8'h40;

  // byte positions within one job's output run
  localparam int HDR_LEN = 12;
  localparam logic [3:0] POS_HDR_FIRST = 4'd0;
  localparam logic [3:0] POS_FU_IND = 4'd12;
  localparam logic [3:0] POS_FU_HDR = 4'd13;
  localparam logic [3:0] POS_DATA = 4'd14;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic first_of_nal;
    logic [NAL_LENGTH_FIELD_BITS-1:0] nal_length;
    logic [31:0] frame_timestamp;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic packet_end;
    logic run_last;
    logic sequence_error;
  } result_t;

  // one classified input byte, expanded by the back part
  typedef struct packed {
    logic err;
    logic hdr;
    logic marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic fu;
    logic [7:0] fu_ind;
    logic [7:0] fu_hdr;
    logic has_byte;
    logic [7:0] data;
    logic data_end;
  } job_t;

  // header fields the back part reads from config
  typedef struct packed {
    logic [6:0] payload_type;
    logic [31:0] stream_source_id;
  } hdr_cfg_t;

endpackage

// ===== design/rtpfua_front.sv =====
module rtpfua_front import rtpfua_pkg::*; #(
  parameter int NAL_LENGTH_BITS = NAL_LENGTH_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  item_t item,
  input  logic [10:0] max_payload_bytes,
  output job_t job
);

  localparam int NL = NAL_LENGTH_BITS;

  logic [15:0] sequence_number, sequence_number_next;
  logic [NL-1:0] nal_bytes_left, nal_bytes_left_next;
  logic [10:0] fragment_bytes_left, fragment_bytes_left_next;
  logic fragmented_mode, fragmented_mode_next;
  logic [7:0] fu_indicator_byte, fu_indicator_byte_next;
  logic [7:0] nal_type_bits, nal_type_bits_next;
  logic [31:0] held_timestamp, held_timestamp_next;

  logic [10:0] eff_max;
  logic [10:0] frag_start;
  logic [10:0] frag_dec;
  logic [NL-1:0] len;
  logic [NL-1:0] nl_dec;
  logic err;
  logic fits;
  logic last_frag;

  // classify the byte and work out the next state
  always_comb begin
    priority if (max_payload_bytes < MIN_PAYLOAD) begin
      eff_max = MIN_PAYLOAD;
    end else if (max_payload_bytes > MAX_PAYLOAD) begin
      eff_max = MAX_PAYLOAD;
    end else begin
      eff_max = max_payload_bytes;
    end

    len = NL'(item.nal_length);
    if (len == '0) begin
      len = NL'(1);
    end
    fits = len <= NL'(eff_max);
    last_frag = ({1'b0, nal_bytes_left} + (NL+1)'(2)) <= (NL+1)'(eff_max);

    if (fragment_bytes_left == '0) begin
      frag_start = last_frag ? nal_bytes_left[10:0] : (eff_max - FU_OVERHEAD);
    end else begin
      frag_start = fragment_bytes_left;
    end
    frag_dec = frag_start - 11'd1;
    nl_dec = nal_bytes_left - NL'(1);

    err = item.first_of_nal ^ (nal_bytes_left == '0);

    sequence_number_next = sequence_number;
    nal_bytes_left_next = nal_bytes_left;
    fragment_bytes_left_next = fragment_bytes_left;
    fragmented_mode_next = fragmented_mode;
    fu_indicator_byte_next = fu_indicator_byte;
    nal_type_bits_next = nal_type_bits;
    held_timestamp_next = held_timestamp;

    job.err = 1'b0;
    job.hdr = 1'b0;
    job.marker = 1'b0;
    job.seq = sequence_number;
    job.ts = held_timestamp;
    job.fu = 1'b0;
    job.fu_ind = fu_indicator_byte;
    job.fu_hdr = nal_type_bits;
    job.has_byte = 1'b1;
    job.data = item.nal_byte;
    job.data_end = 1'b0;

    priority if (err) begin
      // out-of-place first flag: drop the byte
      job.err = 1'b1;
      job.data = 8'h00;
    end else if (item.first_of_nal && fits) begin
      // whole nal in one packet
      held_timestamp_next = item.frame_timestamp;
      job.ts = item.frame_timestamp;
      job.hdr = 1'b1;
      job.marker = 1'b1;
      job.data_end = (len == NL'(1));
      fragmented_mode_next = 1'b0;
      fragment_bytes_left_next = '0;
      nal_bytes_left_next = len - NL'(1);
      sequence_number_next = sequence_number + 16'd1;
    end else if (item.first_of_nal) begin
      // first fu-a fragment, header byte folded into the fu bytes
      held_timestamp_next = item.frame_timestamp;
      job.ts = item.frame_timestamp;
      fu_indicator_byte_next = (item.nal_byte & NRI_F_MASK) | FU_A_TYPE;
      nal_type_bits_next = item.nal_byte & NAL_TYPE_MASK;
      job.hdr = 1'b1;
      job.fu = 1'b1;
      job.fu_ind = fu_indicator_byte_next;
      job.fu_hdr = FU_START_BIT | nal_type_bits_next;
      job.has_byte = 1'b0;
      fragmented_mode_next = 1'b1;
      nal_bytes_left_next = len - NL'(1);
      fragment_bytes_left_next = eff_max - FU_OVERHEAD;
      sequence_number_next = sequence_number + 16'd1;
    end else if (fragmented_mode) begin
      // continuing fragment, opening a new packet when the last one is full
      if (fragment_bytes_left == '0) begin
        job.hdr = 1'b1;
        job.marker = last_frag;
        job.fu = 1'b1;
        job.fu_hdr = (last_frag ? FU_END_BIT : 8'h00) | nal_type_bits;
        sequence_number_next = sequence_number + 16'd1;
      end
      job.data_end = (frag_dec == '0) || (nl_dec == '0);
      nal_bytes_left_next = nl_dec;
      fragment_bytes_left_next = frag_dec;
      if (nl_dec == '0) begin
        fragmented_mode_next = 1'b0;
        fragment_bytes_left_next = '0;
      end
    end else begin
      // payload byte of a single packet
      job.data_end = (nl_dec == '0);
      nal_bytes_left_next = nl_dec;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number <= SEQ_RESET;
      nal_bytes_left <= '0;
      fragment_bytes_left <= '0;
      fragmented_mode <= 1'b0;
      fu_indicator_byte <= '0;
      nal_type_bits <= '0;
      held_timestamp <= '0;
    end else if (accept) begin
      sequence_number <= sequence_number_next;
      nal_bytes_left <= nal_bytes_left_next;
      fragment_bytes_left <= fragment_bytes_left_next;
      fragmented_mode <= fragmented_mode_next;
      fu_indicator_byte <= fu_indicator_byte_next;
      nal_type_bits <= nal_type_bits_next;
      held_timestamp <= held_timestamp_next;
    end
  end

endmodule

// ===== design/rtpfua_queue.sv =====
module rtpfua_queue import rtpfua_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic valid
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  job_t slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full = (count == CNT_BITS'(DEPTH));
  assign valid = (count != '0);
  assign rd_job = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(wr_en) - CNT_BITS'(rd_en);
    end
  end

endmodule

// ===== design/rtpfua_back.sv =====
module rtpfua_back import rtpfua_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_done,
  input  hdr_cfg_t hdr_cfg,
  output result_t result,
  output logic empty,
  input  logic pop
);

  logic started;
  logic [3:0] cur_pos;
  logic [3:0] pos;
  logic [3:0] last_pos;
  logic load;
  logic out_valid;
  logic [7:0] hdr_bytes [HDR_LEN];
  logic [7:0] byte_sel;
  result_t res_next;

  assign load = job_valid && (!out_valid || pop);
  assign job_done = load && (pos == last_pos);
  assign empty = !out_valid;

  // current position in the job's byte run
  always_comb begin
    if (started) begin
      pos = cur_pos;
    end else begin
      pos = job.hdr ? POS_HDR_FIRST : POS_DATA;
    end
    last_pos = job.has_byte ? POS_DATA : POS_FU_HDR;
  end

  // rtp header bytes
  always_comb begin
    hdr_bytes[0] = RTP_VERSION_BYTE;
    hdr_bytes[1] = {job.marker, hdr_cfg.payload_type};
    hdr_bytes[2] = job.seq[15:8];
    hdr_bytes[3] = job.seq[7:0];
    hdr_bytes[4] = job.ts[31:24];
    hdr_bytes[5] = job.ts[23:16];
    hdr_bytes[6] = job.ts[15:8];
    hdr_bytes[7] = job.ts[7:0];
    hdr_bytes[8] = hdr_cfg.stream_source_id[31:24];
    hdr_bytes[9] = hdr_cfg.stream_source_id[23:16];
    hdr_bytes[10] = hdr_cfg.stream_source_id[15:8];
    hdr_bytes[11] = hdr_cfg.stream_source_id[7:0];
  end

  // byte select by position
  always_comb begin
    priority if (pos == POS_DATA) begin
      byte_sel = job.data;
    end else if (pos == POS_FU_HDR) begin
      byte_sel = job.fu_hdr;
    end else if (pos == POS_FU_IND) begin
      byte_sel = job.fu_ind;
    end else if (pos < 4'(HDR_LEN)) begin
      byte_sel = hdr_bytes[pos];
    end else begin
      byte_sel = 8'h00;
    end
    res_next.out_byte = byte_sel;
    res_next.packet_end = (pos == POS_DATA) && job.data_end;
    res_next.run_last = (pos == last_pos);
    res_next.sequence_error = job.err;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

  // run tracking and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      cur_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (pos == last_pos) begin
          started <= 1'b0;
        end else begin
          started <= 1'b1;
          // a single packet skips the fu bytes after its header
          if ((pos == 4'(HDR_LEN - 1)) && !job.fu) begin
            cur_pos <= POS_DATA;
          end else begin
            cur_pos <= pos + 4'd1;
          end
        end
      end
    end
  end

endmodule

// ===== design/rtp_h264_fua_packetizer.sv =====
// RTP packetizer for H.264 NAL units with FU-A fragmentation.
// Input channel (push/full) takes one NAL byte per transfer; the header byte
// carries first_of_nal, nal_length and frame_timestamp. Result channel
// (empty/pop) delivers RTP packet bytes, one per transfer, with packet_end on
// the last byte of each packet and run_last on the last byte caused by one
// input byte. A byte with an out-of-place first flag is dropped and yields a
// single zero byte with sequence_error set.
// The front classifies each byte combinationally and pushes a job into a
// 4-entry queue; the back expands each job into 1, 13, 14 or 15 bytes at one
// byte per cycle while results are popped. A job's first byte is registered
// in the queue and then in the back's output register. Payload bytes stream
// at one per cycle while results are popped; a packet start adds 12 header
// bytes (14 with the FU indicator and FU header).
// Stalling pop holds the current result; the queue then fills and full rises.
// Reset clears the queue, output valid flag and packetizer state; the sequence
// number restarts at 1 and registers return to payload type 96, SSRC 10 and
// max payload 1460. Configuration is written through the APB port.
module rtp_h264_fua_packetizer import rtpfua_pkg::*; #(
  parameter int NAL_LENGTH_BITS = NAL_LENGTH_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  item_t item,
  output logic empty,
  input  logic pop,
  output result_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [6:0] payload_type;
  logic [31:0] stream_source_id;
  logic [10:0] max_payload_bytes;
  logic [1:0] reg_index;
  logic cfg_write;
  logic accept;
  logic job_valid;
  logic job_done;
  job_t front_job;
  job_t head_job;
  hdr_cfg_t hdr_cfg;

  assign pready = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept = push && !full;
  assign hdr_cfg.payload_type = payload_type;
  assign hdr_cfg.stream_source_id = stream_source_id;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_type <= PAYLOAD_TYPE_RESET;
      stream_source_id <= STREAM_SOURCE_ID_RESET;
      max_payload_bytes <= MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_PAYLOAD_TYPE: payload_type <= pwdata[6:0];
        REG_STREAM_SOURCE_ID: stream_source_id <= pwdata;
        REG_MAX_PAYLOAD_BYTES: max_payload_bytes <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_index)
      REG_PAYLOAD_TYPE: prdata = {25'd0, payload_type};
      REG_STREAM_SOURCE_ID: prdata = stream_source_id;
      REG_MAX_PAYLOAD_BYTES: prdata = {21'd0, max_payload_bytes};
      default: prdata = 32'd0;
    endcase
  end

  // classify input bytes
  rtpfua_front #(
    .NAL_LENGTH_BITS(NAL_LENGTH_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .max_payload_bytes(max_payload_bytes),
    .job(front_job)
  );

  // job queue between front and back
  rtpfua_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(accept),
    .wr_job(front_job),
    .full(full),
    .rd_en(job_done),
    .rd_job(head_job),
    .valid(job_valid)
  );

  // expand jobs into packet bytes
  rtpfua_back u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job(head_job),
    .job_done(job_done),
    .hdr_cfg(hdr_cfg),
    .result(result),
    .empty(empty),
    .pop(pop)
  );

endmodule
